// File: rtl/dbp_pkg.sv
// Shared types and constants for the four-button debounce block.
package dbp_pkg;

  localparam int unsigned NUM_BTN = 4;
  localparam int unsigned DBT_W   = 16;
  localparam int unsigned CODE_W  = 3;

  localparam logic [DBT_W-1:0] DBT_RESET = 16'd50;

  // Button slots in priority order.
  localparam int unsigned SLOT_STOP = 0;
  localparam int unsigned SLOT_GO   = 1;
  localparam int unsigned SLOT_HOME = 2;
  localparam int unsigned SLOT_LOCK = 3;

  // Event codes.
  localparam logic [CODE_W-1:0] EV_NONE     = 3'd0;
  localparam logic [CODE_W-1:0] EV_STOP_PRS = 3'd1;
  localparam logic [CODE_W-1:0] EV_STOP_REL = 3'd2;
  localparam logic [CODE_W-1:0] EV_GO       = 3'd3;
  localparam logic [CODE_W-1:0] EV_HOME     = 3'd4;
  localparam logic [CODE_W-1:0] EV_LOCK     = 3'd5;

  typedef logic [CODE_W-1:0] code_t;

  // Status of one button for the current word.
  typedef struct packed {
    logic fire;     // stable level flips this word
    logic pressed;  // new stable level is low
  } btn_stat_t;

endpackage

// File: rtl/four_button_debounce_priority_events_core.sv
// Each input word is held in the input register, then its result in the result
// register. Throughput: one poll word per cycle while out_stall is low; each register
// holds one word, so one more input word is taken while a result waits.
// Reset (rst_n low at a clock edge): all buttons released, change times zero,
// debounce time 50 ms, both pipeline registers empty.
module four_button_debounce_priority_events_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_raw_estop,
  input  logic                      in_raw_go,
  input  logic                      in_raw_home,
  input  logic                      in_raw_lock,
  input  logic [31:0]               in_now_ms,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [dbp_pkg::CODE_W-1:0] out_event_code,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dbp_pkg::DBT_W-1:0] cfg_debounce_time
);
  import dbp_pkg::*;

  logic [DBT_W-1:0]      dbt_r;
  logic                  s1_valid_r;
  logic [NUM_BTN-1:0]    s1_raw_r;
  logic [TIME_WIDTH-1:0] s1_now_r;
  logic                  o_valid_r;
  code_t                 o_code_r;
  code_t                 code_nxt;
  logic                  out_free;
  logic                  s1_step;
  logic                  in_take;
  logic [NUM_BTN-1:0]    exam;
  logic [NUM_BTN-1:0]    ends;
  btn_stat_t             stat [NUM_BTN];

  assign out_free  = !o_valid_r || !out_stall;
  assign s1_step   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid      = o_valid_r;
  assign out_event_code = o_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbt_r <= DBT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dbt_r <= cfg_debounce_time;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r <= {in_raw_lock, in_raw_home, in_raw_go, in_raw_estop};
      s1_now_r <= TIME_WIDTH'(in_now_ms);
    end
  end

  for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
    dbp_btn #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_btn (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (s1_step),
      .exam  (exam[b]),
      .raw   (s1_raw_r[b]),
      .now   (s1_now_r),
      .dbt   (dbt_r),
      .stat  (stat[b])
    );
  end

  // Stop ends the word on any flip; the others only on a press.
  always_comb begin
    ends[SLOT_STOP] = stat[SLOT_STOP].fire;
    ends[SLOT_GO]   = stat[SLOT_GO].fire && stat[SLOT_GO].pressed;
    ends[SLOT_HOME] = stat[SLOT_HOME].fire && stat[SLOT_HOME].pressed;
    ends[SLOT_LOCK] = stat[SLOT_LOCK].fire && stat[SLOT_LOCK].pressed;
    exam[SLOT_STOP] = 1'b1;
    exam[SLOT_GO]   = !ends[SLOT_STOP];
    exam[SLOT_HOME] = exam[SLOT_GO] && !ends[SLOT_GO];
    exam[SLOT_LOCK] = exam[SLOT_HOME] && !ends[SLOT_HOME];
    if (ends[SLOT_STOP]) begin
      code_nxt = stat[SLOT_STOP].pressed ? EV_STOP_PRS : EV_STOP_REL;
    end else if (ends[SLOT_GO]) begin
      code_nxt = EV_GO;
    end else if (ends[SLOT_HOME]) begin
      code_nxt = EV_HOME;
    end else if (ends[SLOT_LOCK]) begin
      code_nxt = EV_LOCK;
    end else begin
      code_nxt = EV_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s1_step) begin
      o_valid_r <= 1'b1;
    end else if (!out_stall) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step) begin
      o_code_r <= code_nxt;
    end
  end

endmodule

// File: rtl/dbp_btn.sv
// Debounce state and settle logic for one button.
module dbp_btn #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,     // word processed this cycle
  input  logic                           exam,     // button examined in this word
  input  logic                           raw,
  input  logic [TIME_WIDTH-1:0]          now,
  input  logic [dbp_pkg::DBT_W-1:0]      dbt,
  output dbp_pkg::btn_stat_t             stat
);
  import dbp_pkg::*;

  localparam int unsigned CW = (TIME_WIDTH > DBT_W) ? TIME_WIDTH : DBT_W;

  logic                  last_raw_r;
  logic                  stable_r;
  logic [TIME_WIDTH-1:0] chg_time_r;
  logic                  raw_moved;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  held;

  always_comb begin
    raw_moved    = (raw != last_raw_r);
    // a fresh raw change restarts the timer, so nothing has elapsed yet
    elapsed      = raw_moved ? '0 : (now - chg_time_r);
    held         = (CW'(elapsed) >= CW'(dbt));
    stat.fire    = held && (raw != stable_r);
    stat.pressed = !raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      stable_r   <= 1'b1;
      chg_time_r <= '0;
    end else if (step && exam) begin
      last_raw_r <= raw;
      if (raw_moved) begin
        chg_time_r <= now;
      end
      if (stat.fire) begin
        stable_r <= raw;
      end
    end
  end

endmodule
